/* sv/grid_window_cell_range_core_assert.svh */
// assertion macros for the grid window cell range core checks
`ifndef GRID_WINDOW_CELL_RANGE_CORE_ASSERT_SVH
`define GRID_WINDOW_CELL_RANGE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GWCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gwcr check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define GWCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gwcr check failed");

`endif

/* sv/gwcr_pkg.sv */
// shared constants, types and helpers of the grid window cell range core
package gwcr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int HALF_W      = 30;
  localparam int CELL_W      = 31;
  localparam int OUT_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 128;
  localparam int SUM_W       = ((COORD_WIDTH > HALF_W + 1) ? COORD_WIDTH : HALF_W + 1) + 1;

  localparam int NLANE   = 4;
  localparam int LANE_XL = 0;
  localparam int LANE_XH = 1;
  localparam int LANE_YL = 2;
  localparam int LANE_YH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_Y_MIN  = 3'd1,
    REG_X_MAX  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_CELL_W = 3'd4,
    REG_CELL_H = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CELL_W-1:0]      rem;
    logic [COORD_WIDTH-1:0] word;
  } div_lane_t;

  typedef struct packed {
    logic                        hit;
    div_lane_t [NLANE-1:0]       lane;
  } cell_data_t;

  typedef struct packed {
    logic                   hit;
    logic [COORD_WIDTH-1:0] off_lo;
    logic [COORD_WIDTH-1:0] off_hi;
  } axis_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] row_count;
    logic [OUT_W-1:0] col_count;
    logic [OUT_W-1:0] first_row;
    logic [OUT_W-1:0] first_col;
  } result_t;

  function automatic logic signed [SUM_W-1:0] coord_ext(input logic [COORD_WIDTH-1:0] v);
    return {{(SUM_W - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

endpackage

/* sv/grid_window_cell_range_core.sv */
// top level of the grid window cell range core
// Takes one query (centre and half size) per cycle and returns, for each, the
// first covered column and row and the covered column and row counts of the
// window clipped to the configured region, or a miss with all fields zero.
// Two front stages form and clip the window, then a chain of COORD_WIDTH division
// cells each retires one quotient bit of all four offset divisions, and the
// result lands in a two-entry output buffer. Throughput is one item per cycle;
// when the buffer fills, in_tready drops and the whole chain holds. The user
// must write registers through the cfg port only while no item is in flight;
// the block itself does not enforce this.
module grid_window_cell_range_core import gwcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // point_x, point_y, half_size, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // first_col, first_row, col_count, row_count
  output logic                  out_tuser,  // hit
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [COORD_WIDTH-1:0] x_min_r, y_min_r, x_max_r, y_max_r;
  logic [CELL_W-1:0]      cell_w_r, cell_h_r;
  logic [CELL_W-1:0]      d_x, d_y;
  logic                   en;
  logic                   chain_valid [COORD_WIDTH+1];
  cell_data_t             chain_data  [COORD_WIDTH+1];
  result_t                res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= '0;
      y_min_r  <= '0;
      x_max_r  <= '0;
      y_max_r  <= '0;
      cell_w_r <= CELL_W'(1);
      cell_h_r <= CELL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_MIN:  x_min_r  <= cfg_wdata[COORD_WIDTH-1:0];
        REG_Y_MIN:  y_min_r  <= cfg_wdata[COORD_WIDTH-1:0];
        REG_X_MAX:  x_max_r  <= cfg_wdata[COORD_WIDTH-1:0];
        REG_Y_MAX:  y_max_r  <= cfg_wdata[COORD_WIDTH-1:0];
        REG_CELL_W: cell_w_r <= cfg_wdata[CELL_W-1:0];
        REG_CELL_H: cell_h_r <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero cell size behaves as one
  assign d_x = (cell_w_r == '0) ? CELL_W'(1) : cell_w_r;
  assign d_y = (cell_h_r == '0) ? CELL_W'(1) : cell_h_r;

  assign in_tready = en;

  gwcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .take      (in_tvalid && in_tready),
    .point_x   (in_tdata[FIELD_W-1:0]),
    .point_y   (in_tdata[2*FIELD_W-1:FIELD_W]),
    .half_size (in_tdata[2*FIELD_W+HALF_W-1:2*FIELD_W]),
    .x_min     (x_min_r),
    .y_min     (y_min_r),
    .x_max     (x_max_r),
    .y_max     (y_max_r),
    .valid_o   (chain_valid[0]),
    .data_o    (chain_data[0])
  );

  for (genvar g = 0; g < COORD_WIDTH; g++) begin : g_cell
    gwcr_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .d_x     (d_x),
      .d_y     (d_y),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  gwcr_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chain_valid[COORD_WIDTH]),
    .data_i  (chain_data[COORD_WIDTH]),
    .ready_i (out_tready),
    .en_o    (en),
    .valid_o (out_tvalid),
    .res_o   (res)
  );

  assign out_tdata = {res.row_count, res.col_count, res.first_row, res.first_col};
  assign out_tuser = res.hit;

endmodule

/* sv/gwcr_front.sv */
// window forming, clipping to the region and offset calculation ahead of the divider chain
module gwcr_front import gwcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   take,
  input  logic [FIELD_W-1:0]     point_x,
  input  logic [FIELD_W-1:0]     point_y,
  input  logic [HALF_W-1:0]      half_size,
  input  logic [COORD_WIDTH-1:0] x_min,
  input  logic [COORD_WIDTH-1:0] y_min,
  input  logic [COORD_WIDTH-1:0] x_max,
  input  logic [COORD_WIDTH-1:0] y_max,
  output logic                   valid_o,
  output cell_data_t             data_o
);

  logic                    v1_r;
  logic signed [SUM_W-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic signed [SUM_W-1:0] lo_x_nxt, hi_x_nxt, lo_y_nxt, hi_y_nxt;
  logic signed [SUM_W-1:0] rad;
  logic                    v2_r;
  cell_data_t              data_r, data_nxt;
  axis_t                   ax, ay;

  function automatic axis_t clip_axis(input logic signed [SUM_W-1:0] lo,
                                      input logic signed [SUM_W-1:0] hi,
                                      input logic signed [SUM_W-1:0] lo_e,
                                      input logic signed [SUM_W-1:0] hi_e);
    logic signed [SUM_W-1:0] lo_c, hi_c, d_lo, d_hi;
    axis_t a;
    lo_c     = (lo < lo_e) ? lo_e : lo;
    hi_c     = (hi > hi_e) ? hi_e : hi;
    d_lo     = lo_c - lo_e;
    d_hi     = hi_c - lo_e;
    a.hit    = !((hi_c <= lo_e) || (lo_c >= hi_e));
    a.off_lo = d_lo[COORD_WIDTH-1:0];
    a.off_hi = d_hi[COORD_WIDTH-1:0];
    return a;
  endfunction

  // window edges
  always_comb begin
    rad      = $signed({{(SUM_W - HALF_W){1'b0}}, half_size});
    lo_x_nxt = coord_ext(point_x[COORD_WIDTH-1:0]) - rad;
    hi_x_nxt = coord_ext(point_x[COORD_WIDTH-1:0]) + rad;
    lo_y_nxt = coord_ext(point_y[COORD_WIDTH-1:0]) - rad;
    hi_y_nxt = coord_ext(point_y[COORD_WIDTH-1:0]) + rad;
  end

  // clip and measure from the region origin
  always_comb begin
    ax = clip_axis(lo_x_r, hi_x_r, coord_ext(x_min), coord_ext(x_max));
    ay = clip_axis(lo_y_r, hi_y_r, coord_ext(y_min), coord_ext(y_max));
    data_nxt                    = '0;
    data_nxt.hit                = ax.hit & ay.hit;
    data_nxt.lane[LANE_XL].word = ax.off_lo;
    data_nxt.lane[LANE_XH].word = ax.off_hi;
    data_nxt.lane[LANE_YL].word = ay.off_lo;
    data_nxt.lane[LANE_YH].word = ay.off_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= take;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_x_r <= lo_x_nxt;
      hi_x_r <= hi_x_nxt;
      lo_y_r <= lo_y_nxt;
      hi_y_r <= hi_y_nxt;
      data_r <= data_nxt;
    end
  end

  assign valid_o = v2_r;
  assign data_o  = data_r;

endmodule

/* sv/gwcr_div_cell.sv */
// one restoring division step on all four lanes, one quotient bit per cell
module gwcr_div_cell import gwcr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [CELL_W-1:0] d_x,
  input  logic [CELL_W-1:0] d_y,
  input  logic              valid_i,
  input  cell_data_t        data_i,
  output logic              valid_o,
  output cell_data_t        data_o
);

  logic              valid_r;
  cell_data_t        data_r, data_nxt;
  logic [CELL_W-1:0] div [NLANE];

  assign div[LANE_XL] = d_x;
  assign div[LANE_XH] = d_x;
  assign div[LANE_YL] = d_y;
  assign div[LANE_YH] = d_y;

  always_comb begin
    logic [CELL_W:0] t;
    logic [CELL_W:0] diff;
    logic            ge;
    data_nxt     = data_i;
    for (int i = 0; i < NLANE; i++) begin
      t    = {data_i.lane[i].rem, data_i.lane[i].word[COORD_WIDTH-1]};
      diff = t - {1'b0, div[i]};
      ge   = (t >= {1'b0, div[i]});
      data_nxt.lane[i].rem  = ge ? diff[CELL_W-1:0] : t[CELL_W-1:0];
      data_nxt.lane[i].word = {data_i.lane[i].word[COORD_WIDTH-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

/* sv/gwcr_out.sv */
// ceiling correction, cell counts, miss masking and two-entry output buffer
module gwcr_out import gwcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  input  cell_data_t data_i,
  input  logic       ready_i,
  output logic       en_o,
  output logic       valid_o,
  output result_t    res_o
);

  logic               main_valid_r, skid_valid_r;
  result_t            main_r, skid_r;
  result_t            res_nxt;
  logic [COORD_WIDTH:0] cnt_x, cnt_y;
  logic               push, pop;

  always_comb begin
    cnt_x = {1'b0, data_i.lane[LANE_XH].word} - {1'b0, data_i.lane[LANE_XL].word}
            + {{COORD_WIDTH{1'b0}}, (data_i.lane[LANE_XH].rem != '0)};
    cnt_y = {1'b0, data_i.lane[LANE_YH].word} - {1'b0, data_i.lane[LANE_YL].word}
            + {{COORD_WIDTH{1'b0}}, (data_i.lane[LANE_YH].rem != '0)};
    res_nxt = '0;
    if (data_i.hit) begin
      res_nxt.hit       = 1'b1;
      res_nxt.first_col = OUT_W'(data_i.lane[LANE_XL].word);
      res_nxt.first_row = OUT_W'(data_i.lane[LANE_YL].word);
      res_nxt.col_count = OUT_W'(cnt_x);
      res_nxt.row_count = OUT_W'(cnt_y);
    end
  end

  assign en_o = !skid_valid_r;
  assign push = en_o && valid_i;
  assign pop  = main_valid_r && ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_r <= res_nxt;
      end else begin
        main_r <= res_nxt;
      end
    end
  end

  assign valid_o = main_valid_r;
  assign res_o   = main_r;

endmodule

/* sv/gwcr_checker.sv */
// port-level checks of the grid window cell range core and their binding
`include "grid_window_cell_range_core_assert.svh"

module gwcr_checker import gwcr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // a miss carries all-zero fields
  `GWCR_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0)

  // a stalled result holds
  `GWCR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // input back-pressure only with a result waiting
  `GWCR_ASSERT_IMP(a_stall_cause, !in_tready, out_tvalid)

  // full buffer stays full until the sink takes an item
  `GWCR_ASSERT_NEXT(a_full_holds, !in_tready && !out_tready, !in_tready)

endmodule

bind grid_window_cell_range_core gwcr_checker u_checker (.*);
